### hw/rtl/simon_pkg.sv
// ----------------------------------------------------------------------------
// simon_pkg
// types, register map and variant tables shared by the cipher modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package simon_pkg;

    localparam int WORD_W    = 64;
    localparam int VAR_W     = 3;
    localparam int NUM_REGS  = 5;
    localparam int REG_IDX_W = 3;
    localparam int NUM_KEYS  = 4;
    localparam int Z_PERIOD  = 62;
    localparam int Z_IDX_W   = 6;

    // register map, one 64-bit register every eight bytes
    localparam logic [REG_IDX_W-1:0] REG_VARIANT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KEY0    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KEY1    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KEY2    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_KEY3    = 3'd4;

    // block/key sizes
    localparam logic [VAR_W-1:0] VAR_32_64   = 3'd0;
    localparam logic [VAR_W-1:0] VAR_48_96   = 3'd1;
    localparam logic [VAR_W-1:0] VAR_64_128  = 3'd2;
    localparam logic [VAR_W-1:0] VAR_96_144  = 3'd3;
    localparam logic [VAR_W-1:0] VAR_128_256 = 3'd4;

    localparam logic [WORD_W-1:0] Z0 = 64'h19C3_522F_B386_A45F;
    localparam logic [WORD_W-1:0] Z1 = 64'h1686_4FB8_AD0C_9F71;
    localparam logic [WORD_W-1:0] Z3 = 64'h3C2C_E512_07A6_35DB;
    localparam logic [WORD_W-1:0] Z4 = 64'h3DC9_4C3A_046D_678B;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] result_first;
        logic [WORD_W-1:0] result_second;
    } t_res;

    typedef enum logic [1:0] {
        ST_KLOAD,
        ST_EXPAND,
        ST_IDLE,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic key_load;
        logic key_step;
        logic blk_load;
        logic blk_round;
        logic blk_last;
    } t_dp_cmd;

    function automatic logic [VAR_W-1:0] eff_variant(input logic [VAR_W-1:0] v);
        return (v > VAR_128_256) ? VAR_128_256 : v;
    endfunction

    function automatic int unsigned word_bits(input logic [VAR_W-1:0] ev);
        unique case (ev)
            VAR_32_64:  return 16;
            VAR_48_96:  return 24;
            VAR_64_128: return 32;
            VAR_96_144: return 48;
            default:    return 64;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] word_mask(input logic [VAR_W-1:0] ev);
        unique case (ev)
            VAR_32_64:  return 64'h0000_0000_0000_FFFF;
            VAR_48_96:  return 64'h0000_0000_00FF_FFFF;
            VAR_64_128: return 64'h0000_0000_FFFF_FFFF;
            VAR_96_144: return 64'h0000_FFFF_FFFF_FFFF;
            default:    return 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    endfunction

    // index of the final round
    function automatic int unsigned round_last(input logic [VAR_W-1:0] ev);
        unique case (ev)
            VAR_32_64:  return 31;
            VAR_48_96:  return 35;
            VAR_64_128: return 43;
            VAR_96_144: return 53;
            default:    return 71;
        endcase
    endfunction

    function automatic logic four_keys(input logic [VAR_W-1:0] ev);
        return ev != VAR_96_144;
    endfunction

    function automatic logic [WORD_W-1:0] z_seq(input logic [VAR_W-1:0] ev);
        unique case (ev)
            VAR_32_64:  return Z0;
            VAR_48_96:  return Z1;
            VAR_64_128: return Z3;
            VAR_96_144: return Z3;
            default:    return Z4;
        endcase
    endfunction

    // rotations within the variant word; upper bits of v must already be zero
    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned r,
                                               input logic [VAR_W-1:0] ev);
        return ((v << r) | (v >> (word_bits(ev) - r))) & word_mask(ev);
    endfunction

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v,
                                               input int unsigned r,
                                               input logic [VAR_W-1:0] ev);
        return ((v >> r) | (v << (word_bits(ev) - r))) & word_mask(ev);
    endfunction

    function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x,
                                              input logic [VAR_W-1:0] ev);
        return (rotl(x, 1, ev) & rotl(x, 8, ev)) ^ rotl(x, 2, ev);
    endfunction

endpackage

### hw/rtl/simon_ram.sv
// ----------------------------------------------------------------------------
// simon_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simon_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 72
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/simon_ctrl.sv
// ----------------------------------------------------------------------------
// simon_ctrl
// sequencer for key expansion and the encrypt/decrypt round loop
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simon_ctrl #(
    parameter int MAX_ROUNDS = 72
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_dec,
    input  logic                          i_cfg_wr,
    input  logic [simon_pkg::VAR_W-1:0]   i_variant,
    output logic                          o_busy,
    output logic                          o_done,
    output simon_pkg::t_dp_cmd            o_cmd,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_ROUNDS)-1:0] o_wr_addr,
    output logic                          o_rd_en,
    output logic [$clog2(MAX_ROUNDS)-1:0] o_rd_addr
);

    import simon_pkg::*;

    localparam int AW = $clog2(MAX_ROUNDS);

    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_dec, n_dec;
    logic          r_done;
    logic [AW-1:0] last_idx;
    logic          at_last;

    assign last_idx = AW'(round_last(i_variant));
    assign at_last  = (r_cnt == last_idx);

    // next state: any register write rebuilds the key schedule
    always_comb begin
        n_state = r_state;
        if (i_cfg_wr) begin
            n_state = ST_KLOAD;
        end else begin
            unique case (r_state)
                ST_KLOAD:  n_state = ST_EXPAND;
                ST_EXPAND: if (at_last) n_state = ST_IDLE;
                ST_IDLE:   if (i_start) n_state = ST_ROUND;
                ST_ROUND:  if (at_last) n_state = ST_IDLE;
                default:   n_state = ST_KLOAD;
            endcase
        end
    end

    always_comb begin
        n_cnt     = r_cnt;
        n_dec     = r_dec;
        o_cmd     = '0;
        o_wr_en   = 1'b0;
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        unique case (r_state)
            ST_KLOAD: begin
                o_cmd.key_load = 1'b1;
                n_cnt          = '0;
            end
            ST_EXPAND: begin
                o_cmd.key_step = 1'b1;
                o_wr_en        = 1'b1;
                n_cnt          = r_cnt + 1'b1;
            end
            ST_IDLE: begin
                n_cnt = '0;
                if (i_start) begin
                    o_cmd.blk_load = 1'b1;
                    n_dec          = i_dec;
                    o_rd_en        = 1'b1;
                    o_rd_addr      = i_dec ? last_idx : '0;
                end
            end
            ST_ROUND: begin
                o_cmd.blk_round = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (at_last) begin
                    o_cmd.blk_last = 1'b1;
                end else begin
                    // fetch the key of the following round
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_dec ? (last_idx - r_cnt - 1'b1) : (r_cnt + 1'b1);
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_KLOAD;
            r_cnt   <= '0;
            r_dec   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dec   <= n_dec;
            r_done  <= o_cmd.blk_last;
        end
    end

    assign o_wr_addr = r_cnt;
    assign o_busy    = (r_state != ST_IDLE);
    assign o_done    = r_done;

endmodule

### hw/rtl/simon_datapath.sv
// ----------------------------------------------------------------------------
// simon_datapath
// key schedule step, shared round unit and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simon_datapath (
    input  logic                                               i_clk,
    input  simon_pkg::t_dp_cmd                                 i_cmd,
    input  logic [simon_pkg::VAR_W-1:0]                        i_variant,
    input  logic [simon_pkg::NUM_KEYS-1:0][simon_pkg::WORD_W-1:0] i_keys,
    input  simon_pkg::t_req                                    i_req,
    input  logic [simon_pkg::WORD_W-1:0]                       i_rkey,
    output logic [simon_pkg::WORD_W-1:0]                       o_kword,
    output simon_pkg::t_res                                    o_result
);

    import simon_pkg::*;

    logic [NUM_KEYS-1:0][WORD_W-1:0] r_k;
    logic [Z_IDX_W-1:0]              r_zidx;
    logic [WORD_W-1:0]               r_x, r_y;
    logic                            r_dec;
    t_res                            r_res;

    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] z_word;
    logic [WORD_W-1:0] t_rot, t_mix, nk;
    logic [WORD_W-1:0] nx;
    logic              four;

    assign mask   = word_mask(i_variant);
    assign four   = four_keys(i_variant);
    assign z_word = z_seq(i_variant);

    // next key word of the schedule
    always_comb begin
        t_rot = four ? (rotr(r_k[3], 3, i_variant) ^ r_k[1]) : rotr(r_k[2], 3, i_variant);
        t_mix = t_rot ^ rotr(t_rot, 1, i_variant);
        nk    = (~r_k[0] ^ t_mix ^ WORD_W'(3) ^ WORD_W'(z_word[r_zidx])) & mask;
    end

    assign nx = (mix(r_x, i_variant) ^ r_y ^ i_rkey) & mask;

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_k[i] <= i_keys[i] & mask;
            end
            r_zidx <= '0;
        end else if (i_cmd.key_step) begin
            r_k[0] <= r_k[1];
            r_k[1] <= r_k[2];
            r_k[2] <= four ? r_k[3] : nk;
            r_k[3] <= nk;
            r_zidx <= (r_zidx == Z_IDX_W'(Z_PERIOD - 1)) ? '0 : r_zidx + 1'b1;
        end

        if (i_cmd.blk_load) begin
            r_dec <= i_req.cmd;
            // encrypt takes y then x, decrypt takes x then y
            if (i_req.cmd) begin
                r_x <= i_req.first_word & mask;
                r_y <= i_req.second_word & mask;
            end else begin
                r_x <= i_req.second_word & mask;
                r_y <= i_req.first_word & mask;
            end
        end else if (i_cmd.blk_round) begin
            r_x <= nx;
            r_y <= r_x;
        end

        if (i_cmd.blk_last) begin
            if (r_dec) begin
                r_res.result_first  <= nx;
                r_res.result_second <= r_x;
            end else begin
                r_res.result_first  <= r_x;
                r_res.result_second <= nx;
            end
        end
    end

    assign o_kword  = r_k[0];
    assign o_result = r_res;

endmodule

### hw/rtl/simon_block_cipher_top.sv
// ----------------------------------------------------------------------------
// simon_block_cipher_top: o_valid and o_result are registered from the final round
// one round per cycle on the shared round unit; next request taken in the same cycle as o_valid
// reset and every write to a mapped register rebuild the round keys (KLOAD, EXPAND)
// o_valid pulses for one cycle, the receiver cannot stall; busy blocks start
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module simon_block_cipher_top #(
    parameter int MAX_ROUNDS = 72
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  simon_pkg::t_req                i_req,
    output logic                           o_valid,
    output simon_pkg::t_res                o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [5:0]                     paddr,
    input  logic [simon_pkg::WORD_W-1:0]   pwdata,
    output logic [simon_pkg::WORD_W-1:0]   prdata,
    output logic                           pready
);

    import simon_pkg::*;

    localparam int AW = $clog2(MAX_ROUNDS);

    logic [VAR_W-1:0]                r_variant;
    logic [NUM_KEYS-1:0][WORD_W-1:0] r_keys;

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 apb_wr;
    logic                 cfg_wr;
    logic [VAR_W-1:0]     ev;

    t_dp_cmd           dp_cmd;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0] kword, rkey;

    assign reg_idx = paddr[5:3];
    assign apb_wr  = psel && penable && pwrite;
    // writes beyond the register list are dropped
    assign cfg_wr  = apb_wr && (reg_idx < REG_IDX_W'(NUM_REGS));
    assign pready  = 1'b1;
    assign ev      = eff_variant(r_variant);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= '0;
            r_keys    <= '0;
        end else if (apb_wr) begin
            unique case (reg_idx)
                REG_VARIANT: r_variant <= pwdata[VAR_W-1:0];
                REG_KEY0:    r_keys[0] <= pwdata;
                REG_KEY1:    r_keys[1] <= pwdata;
                REG_KEY2:    r_keys[2] <= pwdata;
                REG_KEY3:    r_keys[3] <= pwdata;
                default:     r_variant <= r_variant;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_VARIANT: prdata = WORD_W'(r_variant);
            REG_KEY0:    prdata = r_keys[0];
            REG_KEY1:    prdata = r_keys[1];
            REG_KEY2:    prdata = r_keys[2];
            REG_KEY3:    prdata = r_keys[3];
            default:     prdata = '0;
        endcase
    end

    simon_ctrl #(
        .MAX_ROUNDS(MAX_ROUNDS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_dec     (i_req.cmd),
        .i_cfg_wr  (cfg_wr),
        .i_variant (ev),
        .o_busy    (busy),
        .o_done    (o_valid),
        .o_cmd     (dp_cmd),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr)
    );

    simon_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_ROUNDS)
    ) u_rkey_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (kword),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rkey)
    );

    simon_datapath u_datapath (
        .i_clk     (i_clk),
        .i_cmd     (dp_cmd),
        .i_variant (ev),
        .i_keys    (r_keys),
        .i_req     (i_req),
        .i_rkey    (rkey),
        .o_kword   (kword),
        .o_result  (o_result)
    );

`ifndef SYNTHESIS
    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !cfg_wr) |=> busy)
        else $error("accepted request did not raise busy");

    a_cfg_rebuilds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> busy)
        else $error("register write did not start key expansion");

    a_high_bits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (((o_result.result_first | o_result.result_second)
                      & ~word_mask(ev)) == '0))
        else $error("result bits above the word width are set");
`endif

endmodule

### test/tb_simon_block_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_simon_block_cipher_top
// self-checking bench: a local key schedule and round loop predict every block,
// the variant and key registers are swept over the APB port between phases
// ----------------------------------------------------------------------------

module tb_simon_block_cipher_top;

    import simon_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SCHED_LEN       = 72;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 96;
    localparam int MAX_GAP         = 20;
    localparam int DRAIN_CYCLES    = 80;

    localparam logic       CMD_ENCRYPT  = 1'b0;
    localparam logic       CMD_DECRYPT  = 1'b1;
    localparam logic [2:0] VAR_CODE_TOP = 3'd7;
    localparam logic [2:0] REG_IDX_TOP  = 3'd7;

    localparam logic [63:0] SEQ_Z0 = 64'h19C3_522F_B386_A45F;
    localparam logic [63:0] SEQ_Z1 = 64'h1686_4FB8_AD0C_9F71;
    localparam logic [63:0] SEQ_Z3 = 64'h3C2C_E512_07A6_35DB;
    localparam logic [63:0] SEQ_Z4 = 64'h3DC9_4C3A_046D_678B;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_req        i_req   = '0;
    logic        o_valid;
    t_res        o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [5:0]  paddr   = '0;
    logic [63:0] pwdata  = '0;
    logic [63:0] prdata;
    logic        pready;

    // local copy of the register file and the round keys
    logic [2:0]  cfg_variant = VAR_32_64;
    logic [63:0] key_reg [4] = '{default: '0};
    logic [63:0] round_key [SCHED_LEN];

    t_res        pending_blocks [$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    simon_block_cipher_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simon_block_cipher_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // codes above four behave as the largest variant
    function automatic void variant_shape(output int unsigned n, output int unsigned m,
                                          output int unsigned rounds,
                                          output logic [63:0] z);
        logic [2:0] v;
        v = (cfg_variant > VAR_128_256) ? VAR_128_256 : cfg_variant;
        case (v)
            VAR_32_64: begin
                n = 16; m = 4; rounds = 32; z = SEQ_Z0;
            end
            VAR_48_96: begin
                n = 24; m = 4; rounds = 36; z = SEQ_Z1;
            end
            VAR_64_128: begin
                n = 32; m = 4; rounds = 44; z = SEQ_Z3;
            end
            VAR_96_144: begin
                n = 48; m = 3; rounds = 54; z = SEQ_Z3;
            end
            default: begin
                n = 64; m = 4; rounds = 72; z = SEQ_Z4;
            end
        endcase
    endfunction

    function automatic logic [63:0] mask_of(int unsigned n);
        return {64{1'b1}} >> (64 - n);
    endfunction

    function automatic logic [63:0] rot_left(logic [63:0] v, int unsigned r, int unsigned n);
        return ((v << r) | (v >> (n - r))) & mask_of(n);
    endfunction

    function automatic logic [63:0] rot_right(logic [63:0] v, int unsigned r, int unsigned n);
        return ((v >> r) | (v << (n - r))) & mask_of(n);
    endfunction

    function automatic logic [63:0] round_f(logic [63:0] x, int unsigned n);
        return (rot_left(x, 1, n) & rot_left(x, 8, n)) ^ rot_left(x, 2, n);
    endfunction

    function automatic void rebuild_schedule();
        int unsigned n, m, rounds;
        logic [63:0] z, msk, t, nk;
        logic [63:0] k [4];
        int          i, j;
        variant_shape(n, m, rounds, z);
        msk = mask_of(n);
        for (i = 0; i < 4; i++)
            k[i] = key_reg[i] & msk;
        for (i = 0; i < SCHED_LEN; i++)
            round_key[i] = '0;
        round_key[0] = k[0];
        for (i = 0; i + 1 < rounds; i++) begin
            t = rot_right(k[m-1], 3, n);
            if (m == 4)
                t = t ^ k[1];
            t = t ^ rot_right(t, 1, n);
            nk = (~k[0] ^ t ^ 64'd3 ^ ((z >> (i % Z_PERIOD)) & 64'd1)) & msk;
            for (j = 0; j + 1 < m; j++)
                k[j] = k[j+1];
            k[m-1] = nk;
            round_key[i+1] = k[0];
        end
    endfunction

    function automatic t_res cipher_block(t_req rq);
        int unsigned n, m, rounds;
        logic [63:0] z, msk, x, y, t;
        int          i;
        t_res        res;
        variant_shape(n, m, rounds, z);
        msk = mask_of(n);
        if (rq.cmd == CMD_ENCRYPT) begin
            y = rq.first_word & msk;
            x = rq.second_word & msk;
            for (i = 0; i < rounds; i++) begin
                t = round_f(x, n) ^ y;
                y = x;
                x = (t ^ round_key[i]) & msk;
            end
            res.result_first  = y;
            res.result_second = x;
        end else begin
            x = rq.first_word & msk;
            y = rq.second_word & msk;
            for (i = rounds; i > 0; i--) begin
                t = round_f(x, n) ^ y;
                y = x;
                x = (t ^ round_key[i-1]) & msk;
            end
            res.result_first  = x;
            res.result_second = y;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid) begin
            if (pending_blocks.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h/%h",
                                          o_result.result_first, o_result.result_second));
            end else begin
                want = pending_blocks.pop_front();
                if (o_result.result_first !== want.result_first)
                    report_mismatch($sformatf("result_first %h, want %h",
                                              o_result.result_first, want.result_first));
                if (o_result.result_second !== want.result_second)
                    report_mismatch($sformatf("result_second %h, want %h",
                                              o_result.result_second, want.result_second));
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // request is accepted at the first edge where busy is low
    task automatic send_request(t_req rq);
        start <= 1'b1;
        i_req <= rq;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        pending_blocks.push_back(cipher_block(rq));
    endtask

    task automatic send_block(logic cmd, logic [63:0] first, logic [63:0] second);
        t_req rq;
        rq.cmd         = cmd;
        rq.first_word  = first;
        rq.second_word = second;
        send_request(rq);
    endtask

    // idle cycles are counted from the point where the block could take a request
    task automatic sender_gap(int unsigned pct);
        int unsigned n;
        n = 0;
        while (n < MAX_GAP && $urandom_range(99) < pct)
            n++;
        if (n != 0) begin
            start <= 1'b0;
            do @(negedge i_clk); while (busy);
            repeat (n) @(posedge i_clk);
        end
    endtask

    // drains outstanding blocks and waits for the key schedule before writing
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        start <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_VARIANT)
            cfg_variant = value[2:0];
        else if (idx < NUM_REGS)
            key_reg[idx - REG_KEY0] = value;
        rebuild_schedule();
        @(posedge i_clk);
    endtask

    task automatic set_config(logic [2:0] code, logic [63:0] k0, logic [63:0] k1,
                              logic [63:0] k2, logic [63:0] k3);
        write_reg(REG_VARIANT, {61'd0, code});
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // schedule built from the reset key, no register touched yet
    task automatic test_reset_schedule();
        send_block(CMD_ENCRYPT, '0, '0);
        send_block(CMD_DECRYPT, '1, '1);
    endtask

    task automatic test_variant_extremes();
        logic [2:0] code;
        for (code = VAR_32_64; code <= VAR_128_256; code++) begin
            set_config(code, '1, '1, '1, '1);
            send_block(CMD_ENCRYPT, '1, '1);
            send_block(CMD_DECRYPT, '0, '0);
        end
    endtask

    task automatic test_saturated_codes();
        logic [2:0] code;
        code = VAR_128_256;
        do begin
            code++;
            write_reg(REG_VARIANT, {61'd0, code});
            send_block(code[0] ? CMD_DECRYPT : CMD_ENCRYPT, rand_word(), rand_word());
        end while (code != VAR_CODE_TOP);
    endtask

    // writes above the register map must leave the schedule alone
    task automatic test_unmapped_regs();
        logic [2:0] idx;
        set_config(VAR_64_128, rand_word(), rand_word(), rand_word(), rand_word());
        idx = REG_KEY3;
        do begin
            idx++;
            write_reg(idx, rand_word());
            send_block(CMD_ENCRYPT, rand_word(), rand_word());
        end while (idx != REG_IDX_TOP);
    endtask

    task automatic test_random_traffic();
        int unsigned pct;
        int          ph, i;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 3)
                0:       pct = 0;
                1:       pct = 87;
                default: pct = 23;
            endcase
            set_config(3'(ph % 8), rand_word(), rand_word(), rand_word(), rand_word());
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                sender_gap(pct);
                send_block(1'($urandom_range(1)), rand_word(), rand_word());
            end
        end
    endtask

    initial begin
        rebuild_schedule();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // the reset key expansion holds busy until it is done
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);

        test_reset_schedule();
        test_variant_extremes();
        test_saturated_codes();
        test_unmapped_regs();
        test_random_traffic();

        start <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("simon_block_cipher_top regression: pass");
        else
            $display("simon_block_cipher_top regression: fail");
        $finish;
    end

endmodule

### sim.f
hw/rtl/simon_pkg.sv
hw/rtl/simon_ram.sv
hw/rtl/simon_ctrl.sv
hw/rtl/simon_datapath.sv
hw/rtl/simon_block_cipher_top.sv
test/tb_simon_block_cipher_top.sv
